// File: hw/rtl/sgbm_pkg.sv
// Package for the slab grid binning block: register indexes, state codes, cell record type.
// Used by sgbm_store and slab_grid_binning_mean under hw/rtl; depends on nothing.
`timescale 1ns / 1ps
package sgbm_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_CELL_SIZE = 3'd2,
        REG_INV_SIZE  = 3'd3,
        REG_CELLS     = 3'd4
    } reg_idx_t;

    // Operation codes of an input word.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_RD_RD,
        ST_RD_DIV,
        ST_OUT
    } state_t;

    // One cell record in the store.
    typedef struct packed {
        logic [31:0]        count;
        logic signed [63:0] dsum;
        logic signed [63:0] tsum;
        logic signed [63:0] vsum;
    } cell_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // Saturating add of a 32-bit signed value to a 64-bit signed sum.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [31:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {{33{b[31]}}, b};
        if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else r = s[63:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/sgbm_store.sv
// Cell store for the binning block: one synchronous memory of cell records.
// Depends on sgbm_pkg.
`timescale 1ns / 1ps
module sgbm_store #(
    parameter int AW = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  sgbm_pkg::cell_t      wdata,
    input  logic [AW-1:0]        raddr,
    output sgbm_pkg::cell_t      rdata
);

    sgbm_pkg::cell_t mem [2**AW];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sgbm_div.sv
// Restoring divider for one signed 64-bit sum by an unsigned 32-bit count, one bit per cycle.
// Gives the quotient truncated toward zero, saturated to 32 bits. Depends on nothing.
`timescale 1ns / 1ps
module sgbm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic [31:0]        quotient
);

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [32:0] trial;
    logic signed [64:0] sq;

    // One quotient bit each cycle.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[31:0], q_reg[63]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = dividend[63] ? 64'(-dividend) : dividend;
            r_next = '0;
            d_next = divisor;
            neg_next = dividend[63];
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Done rises the cycle after the last quotient bit, once the quotient is complete.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= busy_reg && cnt_reg == 7'd1 && !start;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    // Unsigned quotient fits 64 bits; apply sign and saturate.
    assign sq = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign quotient = (sq > 65'sd2147483647) ? 32'h7FFF_FFFF :
                      (sq < -65'sd2147483648) ? 32'h8000_0000 : sq[31:0];
    assign done = done_reg;

endmodule

// File: hw/rtl/slab_grid_binning_mean.sv
// Add: an add word is accepted, its cell read (ADD_RD) and written back (ADD_WR), and the next
// word taken. Read: a read word of a cell that holds particles shows its result once three
// 64-step dividers working in parallel finish; an empty or out-of-store cell skips them.
// Flow: one word at a time; once a result is taken the block is idle again. Reset: config and
// control registers return to defaults; a clearing pass writes every store entry to zero, one
// a cycle, 2**(2*clog2(GRID_SIDE)) entries (65536 by default), during which no word is taken.
`timescale 1ns / 1ps
module slab_grid_binning_mean #(
    parameter int GRID_SIDE = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] slab_half_width,
    input  logic signed [31:0] density,
    input  logic signed [31:0] temperature,
    input  logic signed [31:0] velocity_divergence,
    input  logic [7:0]  cell_row,
    input  logic [7:0]  cell_col,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] coord_x,
    output logic signed [31:0] coord_y,
    output logic signed [31:0] mean_density,
    output logic signed [31:0] mean_temperature,
    output logic signed [31:0] mean_divergence,
    output logic [31:0] particle_count
);

    localparam int SW = $clog2(GRID_SIDE);
    localparam int AW = 2 * SW;
    localparam logic [10:0] SIDE_L = 11'(GRID_SIDE);

    // Configuration registers.
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [31:0] cell_size_reg, inv_size_reg;
    logic [8:0]  cells_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            cell_size_reg <= 32'd65536;
            inv_size_reg <= 32'd65536;
            cells_reg <= 9'd256;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                sgbm_pkg::REG_ORIGIN_X:  origin_x_reg <= pwdata;
                sgbm_pkg::REG_ORIGIN_Y:  origin_y_reg <= pwdata;
                sgbm_pkg::REG_CELL_SIZE: cell_size_reg <= pwdata;
                sgbm_pkg::REG_INV_SIZE:  inv_size_reg <= pwdata;
                sgbm_pkg::REG_CELLS:     cells_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[4:2])
            sgbm_pkg::REG_ORIGIN_X:  prdata = origin_x_reg;
            sgbm_pkg::REG_ORIGIN_Y:  prdata = origin_y_reg;
            sgbm_pkg::REG_CELL_SIZE: prdata = cell_size_reg;
            sgbm_pkg::REG_INV_SIZE:  prdata = inv_size_reg;
            sgbm_pkg::REG_CELLS:     prdata = {23'd0, cells_reg};
            default:                 prdata = '0;
        endcase
    end

    // Captured word.
    sgbm_pkg::state_t state_reg, state_next;
    logic [AW:0]  clr_reg, clr_next;
    logic [63:0]  px_reg, py_reg, prodx_reg, prody_reg;
    logic         negx_reg, negy_reg, keep_reg, inst_reg;
    logic signed [31:0] d_reg, t_reg, v_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0]  cx_reg, cy_reg, cnt_reg;
    logic [31:0]  md_reg, mt_reg, mv_reg;

    // Axis offsets and z test for an arriving word.
    logic signed [32:0] offx, offy;
    logic [32:0] magx, magy, magz, magh;
    assign offx = {pos_x[31], pos_x} - {origin_x_reg[31], origin_x_reg};
    assign offy = {pos_y[31], pos_y} - {origin_y_reg[31], origin_y_reg};
    assign magx = offx[32] ? 33'(-offx) : offx;
    assign magy = offy[32] ? 33'(-offy) : offy;
    assign magz = pos_z[31] ? 33'(-$signed({pos_z[31], pos_z})) : {1'b0, pos_z};
    assign magh = slab_half_width[31] ? 33'(-$signed({slab_half_width[31], slab_half_width}))
                                      : {1'b0, slab_half_width};

    // Cell indices from registered products; a grid wider than the store acts as the store.
    logic [31:0] qx, qy;
    logic [10:0] limit;
    logic        okx, oky;
    logic [AW-1:0] add_addr;
    assign qx = prodx_reg[63:32];
    assign qy = prody_reg[63:32];
    assign limit = ({2'd0, cells_reg} > SIDE_L) ? SIDE_L : {2'd0, cells_reg};
    assign okx = (!negx_reg || qx == '0) && qx[31:11] == '0 && qx[10:0] < limit;
    assign oky = (!negy_reg || qy == '0) && qy[31:11] == '0 && qy[10:0] < limit;
    assign add_addr = (AW'(qx[10:0]) << SW) | AW'(qy[10:0]);

    // Store interface.
    sgbm_pkg::cell_t rd_cell, wr_cell;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [AW-1:0] rd_addr_in;

    assign rd_addr_in = (AW'(cell_row) << SW) | AW'(cell_col);
    assign raddr = (state_reg == sgbm_pkg::ST_ADD_RD) ? add_addr : addr_reg;

    sgbm_store #(.AW(AW)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wr_cell), .raddr(raddr), .rdata(rd_cell)
    );

    // Dividers for the three means.
    logic dstart, ddone, tdone, vdone;
    logic [31:0] dq, tq, vq;
    sgbm_div u_div_d (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(rd_cell.dsum),
                      .divisor(rd_cell.count), .done(ddone), .quotient(dq));
    sgbm_div u_div_t (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(rd_cell.tsum),
                      .divisor(rd_cell.count), .done(tdone), .quotient(tq));
    sgbm_div u_div_v (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(rd_cell.vsum),
                      .divisor(rd_cell.count), .done(vdone), .quotient(vq));

    logic in_fire;
    logic first_div_reg;
    assign in_fire = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        unique case (state_reg)
            sgbm_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(2**AW - 1)) state_next = sgbm_pkg::ST_IDLE;
            end
            sgbm_pkg::ST_IDLE:
                if (in_fire) state_next = (op == sgbm_pkg::OP_READ) ? sgbm_pkg::ST_RD_RD
                                                                   : sgbm_pkg::ST_ADD_RD;
            sgbm_pkg::ST_ADD_RD: state_next = sgbm_pkg::ST_ADD_WR;
            sgbm_pkg::ST_ADD_WR: state_next = sgbm_pkg::ST_IDLE;
            sgbm_pkg::ST_RD_RD:  state_next = sgbm_pkg::ST_RD_DIV;
            sgbm_pkg::ST_RD_DIV:
                if (!inst_reg || rd_cell.count == '0 || ddone) state_next = sgbm_pkg::ST_OUT;
            sgbm_pkg::ST_OUT:
                if (out_ready) state_next = sgbm_pkg::ST_IDLE;
            default: state_next = sgbm_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready = 1'b0;
        out_valid = 1'b0;
        we = 1'b0;
        waddr = addr_reg;
        wr_cell = '0;
        dstart = 1'b0;
        unique case (state_reg)
            sgbm_pkg::ST_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg[AW-1:0];
            end
            sgbm_pkg::ST_IDLE:  in_ready = 1'b1;
            sgbm_pkg::ST_ADD_WR:
            begin
                we = keep_reg && okx && oky;
                waddr = add_addr;
                wr_cell.count = (rd_cell.count == 32'hFFFF_FFFF) ? rd_cell.count
                                                                 : rd_cell.count + 32'd1;
                wr_cell.dsum = sgbm_pkg::sat_add64(rd_cell.dsum, d_reg);
                wr_cell.tsum = sgbm_pkg::sat_add64(rd_cell.tsum, t_reg);
                wr_cell.vsum = sgbm_pkg::sat_add64(rd_cell.vsum, v_reg);
            end
            sgbm_pkg::ST_RD_RD:  we = 1'b0;
            sgbm_pkg::ST_RD_DIV:
            begin
                // Start the dividers on the first cycle the record is out, if it holds any.
                dstart = first_div_reg && inst_reg && rd_cell.count != '0;
                // Clear the cell once the old record has been captured by the dividers, or at once if it is empty.
                we = inst_reg && (state_next == sgbm_pkg::ST_OUT);
            end
            sgbm_pkg::ST_OUT:    out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgbm_pkg::ST_CLEAR;
            clr_reg <= '0;
            first_div_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            first_div_reg <= (state_reg == sgbm_pkg::ST_RD_RD);
        end
    end

    // Word capture, address and product registers, result registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prodx_reg <= magx[31:0] * inv_size_reg;
            prody_reg <= magy[31:0] * inv_size_reg;
            negx_reg <= offx[32];
            negy_reg <= offy[32];
            keep_reg <= magz <= magh;
            d_reg <= density;
            t_reg <= temperature;
            v_reg <= velocity_divergence;
            inst_reg <= ({3'd0, cell_row} < SIDE_L) && ({3'd0, cell_col} < SIDE_L);
            addr_reg <= rd_addr_in;
            px_reg <= 64'(cell_size_reg) * 64'(cell_row);
            py_reg <= 64'(cell_size_reg) * 64'(cell_col);
        end
        if (state_reg == sgbm_pkg::ST_RD_RD)
        begin
            cx_reg <= sgbm_pkg::sat32($signed({{32{origin_x_reg[31]}}, origin_x_reg})
                                      + $signed(px_reg));
            cy_reg <= sgbm_pkg::sat32($signed({{32{origin_y_reg[31]}}, origin_y_reg})
                                      + $signed(py_reg));
        end
        if (state_reg == sgbm_pkg::ST_RD_DIV && state_next == sgbm_pkg::ST_OUT)
        begin
            cnt_reg <= inst_reg ? rd_cell.count : '0;
            md_reg <= (inst_reg && rd_cell.count != '0) ? dq : '0;
            mt_reg <= (inst_reg && rd_cell.count != '0) ? tq : '0;
            mv_reg <= (inst_reg && rd_cell.count != '0) ? vq : '0;
        end
    end

    assign coord_x = cx_reg;
    assign coord_y = cy_reg;
    assign mean_density = md_reg;
    assign mean_temperature = mt_reg;
    assign mean_divergence = mv_reg;
    assign particle_count = cnt_reg;

`ifndef SYNTHESIS
    a_no_in_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sgbm_pkg::ST_CLEAR |-> !in_ready) else $error("input taken during clear");
    a_out_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input and output both open");
    a_divs_agree: assert property (@(posedge clk) disable iff (!rst_n)
        ddone == tdone && tdone == vdone) else $error("dividers out of step");
`endif

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for slab_grid_binning_mean: directed and random words with
// an in-bench cell-store predictor. Depends on sgbm_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_top;

    localparam int       SIDE        = 256;
    localparam longint   CYCLE_LIMIT = 2000000;
    localparam longint   SMAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint   SMIN        = 64'sh8000_0000_0000_0000;

    // One input word as offered on the input channel.
    typedef struct {
        logic        op;
        logic [31:0] px, py, pz, hw, dens, temp, vdiv;
        logic [7:0]  row, col;
    } particle_word_t;

    // One expected cell report.
    typedef struct {
        logic [31:0] cx, cy, md, mt, mv, pc;
    } cell_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic op = sgbm_pkg::OP_ADD;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, slab_half_width = '0;
    logic signed [31:0] density = '0, temperature = '0, velocity_divergence = '0;
    logic [7:0] cell_row = '0, cell_col = '0;
    logic out_valid, out_ready = 1'b0;
    logic signed [31:0] coord_x, coord_y, mean_density, mean_temperature, mean_divergence;
    logic [31:0] particle_count;

    slab_grid_binning_mean #(.GRID_SIDE(SIDE)) dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the registers and of the cell store (sparse).
    longint          grid_org_x, grid_org_y;
    longint unsigned grid_size, grid_inv, grid_cells;
    int unsigned     binned_count[int];
    longint          density_acc[int], temp_acc[int], div_acc[int];

    cell_report_t cell_reports_q[$];
    int  error_count = 0;
    int  adds_sent = 0, reads_sent = 0, reports_seen = 0;
    int  send_idle_pct = 0, recv_stall_pct = 0;
    int  hold_left = 0;
    longint cycle_count = 0;

    // Clamp a 64-bit value to signed 32 bits.
    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint acc_add(longint a, longint b);
        if (b > 0 && a > SMAX - b) return SMAX;
        if (b < 0 && a < SMIN - b) return SMIN;
        return a + b;
    endfunction

    // Cell index along one axis; returns 0 when the position is outside the grid.
    function automatic bit axis_index(longint pos, longint org, longint unsigned lim,
                                      output longint unsigned idx);
        longint          off;
        longint unsigned mag, q;
        off = pos - org;
        mag = (off < 0) ? -off : off;
        q = (mag * grid_inv) >> 32;
        idx = 0;
        if (off < 0 && q != 0) return 0;
        if (q >= lim) return 0;
        idx = q;
        return 1;
    endfunction

    function automatic logic [31:0] cell_mean(longint sum, int unsigned cnt);
        if (cnt == 0) return 32'd0;
        return clamp32(sum / longint'(cnt));
    endfunction

    // Apply one accepted word to the predictor; a read queues its report.
    function automatic void predict_word(particle_word_t w);
        longint          z, h;
        longint unsigned lim, ix, iy;
        int              a;
        cell_report_t    r;
        if (w.op == sgbm_pkg::OP_ADD) begin
            z = longint'($signed(w.pz));
            h = longint'($signed(w.hw));
            if (z < 0) z = -z;
            if (h < 0) h = -h;
            lim = (grid_cells > SIDE) ? SIDE : grid_cells;
            if (z > h) return;
            if (!axis_index(longint'($signed(w.px)), grid_org_x, lim, ix)) return;
            if (!axis_index(longint'($signed(w.py)), grid_org_y, lim, iy)) return;
            a = int'(ix * SIDE + iy);
            if (!binned_count.exists(a)) begin
                binned_count[a] = 0;
                density_acc[a] = 0;
                temp_acc[a] = 0;
                div_acc[a] = 0;
            end
            if (binned_count[a] != 32'hFFFF_FFFF) binned_count[a]++;
            density_acc[a] = acc_add(density_acc[a], longint'($signed(w.dens)));
            temp_acc[a] = acc_add(temp_acc[a], longint'($signed(w.temp)));
            div_acc[a] = acc_add(div_acc[a], longint'($signed(w.vdiv)));
            return;
        end
        r.cx = clamp32(grid_org_x + longint'(grid_size * w.row));
        r.cy = clamp32(grid_org_y + longint'(grid_size * w.col));
        a = int'(w.row) * SIDE + int'(w.col);
        if (binned_count.exists(a)) begin
            r.md = cell_mean(density_acc[a], binned_count[a]);
            r.mt = cell_mean(temp_acc[a], binned_count[a]);
            r.mv = cell_mean(div_acc[a], binned_count[a]);
            r.pc = binned_count[a];
            binned_count.delete(a);
            density_acc.delete(a);
            temp_acc.delete(a);
            div_acc.delete(a);
        end
        else begin
            r.md = 0;
            r.mt = 0;
            r.mv = 0;
            r.pc = 0;
        end
        cell_reports_q.push_back(r);
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("[%0t] %s: expected %h, got %h", $realtime, field, want, got);
        error_count++;
    endtask

    // Receiver ready, with random stalls and a counted hold-off stretch.
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted report against the oldest expectation.
    always @(posedge clk)
    begin
        cell_report_t r;
        if (rst_n && out_valid && out_ready) begin
            reports_seen++;
            if (cell_reports_q.size() == 0) begin
                report_mismatch("unexpected report", 32'd0, particle_count);
            end
            else begin
                r = cell_reports_q.pop_front();
                if (coord_x !== r.cx) report_mismatch("coord_x", r.cx, coord_x);
                if (coord_y !== r.cy) report_mismatch("coord_y", r.cy, coord_y);
                if (mean_density !== r.md) report_mismatch("mean_density", r.md, mean_density);
                if (mean_temperature !== r.mt)
                    report_mismatch("mean_temperature", r.mt, mean_temperature);
                if (mean_divergence !== r.mv)
                    report_mismatch("mean_divergence", r.mv, mean_divergence);
                if (particle_count !== r.pc)
                    report_mismatch("particle_count", r.pc, particle_count);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("slab_grid_binning_mean: mismatch");
            $finish;
        end
    end

    // Offer one word and hold it until accepted, then maybe idle.
    task automatic send_word(particle_word_t w);
        op <= w.op;
        pos_x <= w.px;
        pos_y <= w.py;
        pos_z <= w.pz;
        slab_half_width <= w.hw;
        density <= w.dens;
        temperature <= w.temp;
        velocity_divergence <= w.vdiv;
        cell_row <= w.row;
        cell_col <= w.col;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_word(w);
        if (w.op == sgbm_pkg::OP_ADD) adds_sent++;
        else reads_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until the block has drained.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cell_reports_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(sgbm_pkg::reg_idx_t idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sgbm_pkg::REG_ORIGIN_X:  grid_org_x = longint'($signed(v));
            sgbm_pkg::REG_ORIGIN_Y:  grid_org_y = longint'($signed(v));
            sgbm_pkg::REG_CELL_SIZE: grid_size = v;
            sgbm_pkg::REG_INV_SIZE:  grid_inv = v;
            sgbm_pkg::REG_CELLS:     grid_cells = v[8:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] sz,
                            logic [31:0] inv, logic [8:0] cells);
        wait_idle();
        write_reg(sgbm_pkg::REG_ORIGIN_X, ox);
        write_reg(sgbm_pkg::REG_ORIGIN_Y, oy);
        write_reg(sgbm_pkg::REG_CELL_SIZE, sz);
        write_reg(sgbm_pkg::REG_INV_SIZE, inv);
        write_reg(sgbm_pkg::REG_CELLS, {23'd0, cells});
    endtask

    function automatic particle_word_t add_word(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [31:0] h,
                                                logic [31:0] d, logic [31:0] t,
                                                logic [31:0] v);
        particle_word_t w;
        w = '{op: sgbm_pkg::OP_ADD, px: x, py: y, pz: z, hw: h, dens: d, temp: t, vdiv: v,
              row: 8'($urandom), col: 8'($urandom)};
        return w;
    endfunction

    function automatic particle_word_t read_word(logic [7:0] r, logic [7:0] c);
        particle_word_t w;
        w = '{op: sgbm_pkg::OP_READ, px: $urandom, py: $urandom, pz: $urandom, hw: $urandom,
              dens: $urandom, temp: $urandom, vdiv: $urandom, row: r, col: c};
        return w;
    endfunction

    // Position that lands in (or near) a chosen cell of the current grid.
    function automatic logic [31:0] cell_pos(longint org, longint unsigned idx);
        logic [31:0] jitter;
        jitter = (grid_size == 0) ? 32'd0 : $urandom_range(32'(grid_size - 1), 0);
        return 32'(org + longint'(idx * grid_size) + longint'(jitter));
    endfunction

    // Random word: mostly in-grid adds and reads of cells in use, the rest noise.
    function automatic particle_word_t random_word();
        longint unsigned lim;
        logic [31:0]     h, z;
        int              pick;
        lim = (grid_cells > SIDE) ? SIDE : grid_cells;
        if (lim == 0) lim = 1;
        pick = $urandom_range(99);
        h = $urandom;
        z = ($urandom_range(9) < 8) ? $signed(h) >>> $urandom_range(31, 1) : $urandom;
        if (pick < 50)
            return add_word(cell_pos(grid_org_x, $urandom_range(32'(lim - 1), 0)),
                            cell_pos(grid_org_y, $urandom_range(32'(lim - 1), 0)),
                            z, h, $urandom, $urandom, $urandom);
        if (pick < 65)
            return add_word($urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
        if (pick < 92)
            return read_word(8'($urandom_range(32'(lim - 1), 0)),
                             8'($urandom_range(32'(lim - 1), 0)));
        return read_word(8'($urandom), 8'($urandom));
    endfunction

    // Extremes of every field and the special cases, on the reset grid and then on three other grids.
    task automatic test_directed();
        send_word(read_word(8'd0, 8'd0));
        send_word(add_word(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
        send_word(add_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_word(add_word(32'h0, 32'h0, 32'h0001_0001, 32'h0001_0000, 32'h1, 32'h1, 32'h1));
        send_word(add_word(32'h0, 32'h0, 32'hFFFF_0000, 32'hFFFE_0000, 32'h5, 32'h6, 32'h7));
        send_word(add_word(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1));
        send_word(add_word(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1));
        send_word(add_word(32'h00FF_FFFF, 32'h00FF_8000, 32'h0, 32'h1, 32'h3, 32'h3, 32'h3));
        send_word(read_word(8'd0, 8'd0));
        send_word(read_word(8'd0, 8'd0));
        send_word(read_word(8'd255, 8'd255));
        send_word(read_word(8'd255, 8'd0));
        wait_idle();
        // Narrow grid: a read beyond the grid in use still reads and clears its cell.
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 9'd2);
        send_word(add_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h9, 32'h9, 32'h9));
        send_word(read_word(8'd0, 8'd0));
        send_word(read_word(8'd255, 8'd255));
        send_word(read_word(8'd7, 8'd200));
        // Empty grid drops every add.
        set_grid(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd0);
        send_word(add_word(32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1));
        send_word(add_word(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1));
        send_word(read_word(8'd0, 8'd0));
        // Grid wider than the store acts as the full store.
        set_grid(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd511);
        send_word(add_word(32'h00FF_0000, 32'h00FF_0000, 32'h0, 32'h0, 32'h4, 32'h4, 32'h4));
        send_word(add_word(32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h4, 32'h4, 32'h4));
        send_word(read_word(8'd255, 8'd255));
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_word(random_word());
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Long receiver hold-off while reads keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_left = 600;
        repeat (12) send_word(random_word());
        repeat (8) send_word(read_word(8'($urandom_range(3)), 8'($urandom_range(3))));
    endtask

    initial
    begin
        grid_org_x = 0;
        grid_org_y = 0;
        grid_size = 32'h0001_0000;
        grid_inv = 32'h0001_0000;
        grid_cells = 256;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        set_grid(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd8);
        test_random(300, 0, 0);
        set_grid(32'hFFFD_0000, 32'h0001_2345, 32'h0000_8000, 32'h0002_0000, 9'd16);
        test_random(300, 52, 0);
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 9'd256);
        test_random(250, 0, 52);
        set_grid(32'h0000_0100, 32'hFFFF_FFFB, 32'h0003_0000, 32'h0000_5555, 9'd5);
        test_random(300, 33, 33);
        test_backpressure();
        set_grid(32'h7FFF_0000, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 9'd1);
        test_random(200, 52, 52);
        set_grid(32'hAAAA_5555, 32'h5555_AAAA, 32'h0000_0000, 32'h0000_0000, 9'd0);
        test_random(100, 0, 0);
        set_grid(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 9'd4);
        test_random(250, 33, 33);

        wait_idle();
        repeat (100) @(posedge clk);
        $display("covered %0d add and %0d read words, %0d cell reports checked",
                 adds_sent, reads_sent, reports_seen);
        $display("seven grid settings, four idle mixes and one long output hold-off");
        if (error_count == 0 && cell_reports_q.size() == 0)
            $display("slab_grid_binning_mean: match");
        else
            $display("slab_grid_binning_mean: mismatch");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/sgbm_pkg.sv
hw/rtl/sgbm_store.sv
hw/rtl/sgbm_div.sv
hw/rtl/slab_grid_binning_mean.sv
dv/tb_top.sv
